/* hw/rtl/hash_set_dedup_insert_defines.svh */
// Assertion macros shared by the hash set RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef HASH_SET_DEDUP_INSERT_DEFINES_SVH
`define HASH_SET_DEDUP_INSERT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HSD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/hsd_pkg.sv */
// Package for the hash set insert block: widths, default sizes, sequencer states.
// Depends on nothing.
`timescale 1ns / 1ps

package hsd_pkg;

  localparam int KEY_W                 = 32;
  localparam int BUCKET_COUNT_DEF      = 1021;
  localparam int SLOTS_PER_BUCKET_DEF  = 4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_BASE,
    ST_KRD,
    ST_CMP,
    ST_DECIDE
  } hsd_state_t;

  // Steps of the remainder unit.
  typedef enum logic [2:0] {
    MP_IDLE,
    MP_MUL_Q,
    MP_MUL_M,
    MP_REDUCE,
    MP_FIX
  } hsd_mod_phase_t;

endpackage

/* hw/rtl/hsd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps

module hsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Read data holds until the next enabled read.
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/hsd_mod_unit.sv */
// Remainder unit: signed 32-bit key modulo the bucket count, non-negative, formed by
// reciprocal multiplication on one shared multiplier. Depends on hsd_pkg.
`timescale 1ns / 1ps

module hsd_mod_unit import hsd_pkg::*; #(
  parameter int BUCKET_COUNT = BUCKET_COUNT_DEF,
  localparam int BW          = $clog2(BUCKET_COUNT)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output logic [BW-1:0]    bucket
);

  // 2^32 mod the bucket count, used to correct the unsigned remainder of a
  // negative key.
  localparam logic [63:0]      WRAP_MOD   = (64'd1 << KEY_W) % 64'(BUCKET_COUNT);
  localparam logic [BW-1:0]    WRAP_C     = BW'(WRAP_MOD);
  localparam logic [BW:0]      DIVISOR    = (BW+1)'(BUCKET_COUNT);
  // floor(2^32 / bucket count). The quotient estimate it gives is exact or one
  // low, so the partial remainder is below twice the bucket count.
  localparam logic [63:0]      RECIP_FULL = (64'd1 << KEY_W) / 64'(BUCKET_COUNT);
  localparam logic [KEY_W-1:0] RECIP      = KEY_W'(RECIP_FULL);
  localparam logic [KEY_W-1:0] DIV_WORD   = KEY_W'(BUCKET_COUNT);

  hsd_mod_phase_t       phase_r, phase_nxt;
  logic                 done_r, done_nxt;
  logic [2*KEY_W-1:0]   prod_r, prod_nxt;
  logic [BW-1:0]        rem_r, rem_nxt;
  logic [BW-1:0]        bucket_r, bucket_nxt;
  logic [KEY_W-1:0]     mul_a;
  logic [KEY_W-1:0]     mul_b;
  logic [2*KEY_W-1:0]   mul_p;
  logic [KEY_W-1:0]     diff;
  logic [BW:0]          part;
  logic [BW-1:0]        fixed;

  // Next step.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      MP_IDLE: begin
        if (start) begin
          phase_nxt = MP_MUL_Q;
        end
      end
      MP_MUL_Q: begin
        phase_nxt = MP_MUL_M;
      end
      MP_MUL_M: begin
        phase_nxt = MP_REDUCE;
      end
      MP_REDUCE: begin
        phase_nxt = MP_FIX;
      end
      default: begin
        phase_nxt = MP_IDLE;
      end
    endcase
  end

  // Operands of the shared multiplier: key times reciprocal first, then the
  // quotient estimate times the bucket count.
  always_comb begin
    mul_a = key;
    mul_b = RECIP;
    case (phase_r)
      MP_MUL_M: begin
        mul_a = prod_r[2*KEY_W-1:KEY_W];
        mul_b = DIV_WORD;
      end
      default: begin
        mul_b = RECIP;
      end
    endcase
  end

  assign mul_p = (2*KEY_W)'(mul_a) * (2*KEY_W)'(mul_b);

  // Partial remainder and its sign correction.
  always_comb begin
    diff = key - prod_r[KEY_W-1:0];
    part = diff[BW:0];
    if (key[KEY_W-1]) begin
      if (rem_r >= WRAP_C) begin
        fixed = rem_r - WRAP_C;
      end else begin
        fixed = BW'({1'b0, rem_r} + DIVISOR - {1'b0, WRAP_C});
      end
    end else begin
      fixed = rem_r;
    end
  end

  always_comb begin
    prod_nxt   = prod_r;
    rem_nxt    = rem_r;
    bucket_nxt = bucket_r;
    done_nxt   = 1'b0;
    case (phase_r)
      MP_MUL_Q: begin
        prod_nxt = mul_p;
      end
      MP_MUL_M: begin
        prod_nxt = mul_p;
      end
      MP_REDUCE: begin
        rem_nxt = (part >= DIVISOR) ? BW'(part - DIVISOR) : part[BW-1:0];
      end
      MP_FIX: begin
        bucket_nxt = fixed;
        done_nxt   = 1'b1;
      end
      default: begin
        done_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MP_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    prod_r   <= prod_nxt;
    rem_r    <= rem_nxt;
    bucket_r <= bucket_nxt;
  end

  assign done   = done_r;
  assign bucket = bucket_r;

endmodule

/* hw/rtl/hash_set_dedup_insert.sv */
// Hash set insert with duplicate removal: top level, sequencer and the two tables.
// Depends on hsd_pkg, hsd_ram, hsd_mod_unit and hash_set_dedup_insert_defines.svh.
`timescale 1ns / 1ps
`include "hash_set_dedup_insert_defines.svh"

// Each input word carries a signed 32-bit key. The key goes to bucket
// (key mod BUCKET_COUNT), taken non-negative, and every valid slot of that
// bucket is compared with it. An absent key is stored in the lowest free
// slot and reported with out_is_new; a key already present is reported with
// both flags low; an absent key whose bucket is full is dropped and reported
// with out_bucket_full. Every input word gives exactly one result word.
// One key is handled at a time: the bucket is formed on one shared
// multiplier (a reciprocal multiply for the quotient estimate, a multiply
// back by the bucket count, one compare-and-subtract and a sign correction),
// the bucket is handed over and its valid mask is read, the stored slots
// are then read one by one from the key RAM and compared in turn, and a
// last step writes the key and the new valid mask back and loads the
// result. The next key can be taken in the cycle after; the block takes no
// new key before it is through with the last one. The result waits in an
// output register, so the next key is taken while the previous result is
// still pending; a result that is still not taken when the next one is
// ready holds the block in its last step. After reset a clearing pass
// writes every bucket's valid mask to zero, one bucket per cycle; in_ready
// stays low until it is done.

module hash_set_dedup_insert import hsd_pkg::*; #(
  parameter int BUCKET_COUNT     = BUCKET_COUNT_DEF,
  parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_is_new,
  output logic                    out_bucket_full
);

  localparam int BW     = $clog2(BUCKET_COUNT);
  localparam int KDEPTH = BUCKET_COUNT * SLOTS_PER_BUCKET;
  localparam int KAW    = $clog2(KDEPTH);
  localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

  // Sequencer state and datapath registers.
  hsd_state_t state_r, state_nxt;

  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [KAW-1:0]    base_r, base_nxt;
  logic [SLOT_W-1:0] slot_cnt_r, slot_cnt_nxt;
  logic              found_r, found_nxt;
  logic [BW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_is_new_r, out_is_new_nxt;
  logic              out_bucket_full_r, out_bucket_full_nxt;

  // Remainder unit.
  logic          mod_start;
  logic          mod_done;
  logic [BW-1:0] mod_bucket;

  // Valid-mask RAM, one mask per bucket.
  logic                        vld_we;
  logic [BW-1:0]               vld_waddr;
  logic [SLOTS_PER_BUCKET-1:0] vld_wdata;
  logic                        vld_re;
  logic [SLOTS_PER_BUCKET-1:0] vld_rdata;

  // Key RAM, slot s of bucket b at b * SLOTS_PER_BUCKET + s.
  logic             key_we;
  logic [KAW-1:0]   key_waddr;
  logic             key_re;
  logic [KAW-1:0]   key_raddr;
  logic [KEY_W-1:0] key_rdata;

  // Free-slot search over the bucket's mask.
  logic              any_free;
  logic [SLOT_W-1:0] free_idx;
  logic              can_emit;
  logic              accept;

  hsd_mod_unit #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start),
    .key    (key_r),
    .done   (mod_done),
    .bucket (mod_bucket)
  );

  hsd_ram #(
    .WIDTH(SLOTS_PER_BUCKET),
    .DEPTH(BUCKET_COUNT)
  ) u_vld_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (vld_waddr),
    .wdata (vld_wdata),
    .re    (vld_re),
    .raddr (mod_bucket),
    .rdata (vld_rdata)
  );

  hsd_ram #(
    .WIDTH(KEY_W),
    .DEPTH(KDEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_r),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // The lowest clear bit of the mask names the slot that a new key takes.
  always_comb begin
    any_free = ~(&vld_rdata);
    free_idx = '0;
    for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
      if (!vld_rdata[s]) begin
        free_idx = SLOT_W'(s);
      end
    end
  end

  // A result may be written when the output register is empty or drains now.
  assign can_emit = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == BW'(BUCKET_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        if (mod_done) begin
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: begin
        state_nxt = ST_KRD;
      end
      ST_KRD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (slot_cnt_r == SLOT_W'(SLOTS_PER_BUCKET - 1)) begin
          state_nxt = ST_DECIDE;
        end else begin
          state_nxt = ST_KRD;
        end
      end
      ST_DECIDE: begin
        if (can_emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control outputs: handshake, remainder start and RAM ports.
  always_comb begin
    in_ready  = 1'b0;
    mod_start = 1'b0;
    vld_we    = 1'b0;
    vld_waddr = mod_bucket;
    vld_wdata = vld_rdata | (SLOTS_PER_BUCKET'(1) << free_idx);
    vld_re    = 1'b0;
    key_we    = 1'b0;
    key_waddr = base_r + KAW'(free_idx);
    key_re    = 1'b0;
    key_raddr = base_r + KAW'(slot_cnt_r);
    case (state_r)
      ST_CLEAR: begin
        vld_we    = 1'b1;
        vld_waddr = clr_cnt_r;
        vld_wdata = '0;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        mod_start = in_valid;
      end
      ST_BASE: begin
        vld_re = 1'b1;
      end
      ST_KRD: begin
        key_re = 1'b1;
      end
      ST_DECIDE: begin
        if (can_emit && !found_r && any_free) begin
          vld_we = 1'b1;
          key_we = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    key_nxt             = key_r;
    base_nxt            = base_r;
    slot_cnt_nxt        = slot_cnt_r;
    found_nxt           = found_r;
    clr_cnt_nxt         = clr_cnt_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_is_new_nxt      = out_is_new_r;
    out_bucket_full_nxt = out_bucket_full_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          key_nxt = in_key;
        end
        found_nxt    = 1'b0;
        slot_cnt_nxt = '0;
      end
      ST_BASE: begin
        base_nxt = KAW'(mod_bucket) * KAW'(SLOTS_PER_BUCKET);
      end
      ST_CMP: begin
        if (vld_rdata[slot_cnt_r] && (key_rdata == key_r)) begin
          found_nxt = 1'b1;
        end
        if (slot_cnt_r != SLOT_W'(SLOTS_PER_BUCKET - 1)) begin
          slot_cnt_nxt = slot_cnt_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (can_emit) begin
          out_valid_nxt       = 1'b1;
          out_is_new_nxt      = !found_r && any_free;
          out_bucket_full_nxt = !found_r && !any_free;
        end
      end
      default: begin
        found_nxt = found_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r             <= key_nxt;
    base_r            <= base_nxt;
    slot_cnt_r        <= slot_cnt_nxt;
    found_r           <= found_nxt;
    out_is_new_r      <= out_is_new_nxt;
    out_bucket_full_r <= out_bucket_full_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_is_new      = out_is_new_r;
  assign out_bucket_full = out_bucket_full_r;

  `HSD_ASSERT_IMPL(a_mod_done_in_hash, mod_done, state_r == ST_HASH, "remainder done outside hash")
  `HSD_ASSERT_IMPL(a_bucket_range, mod_done, mod_bucket <= BW'(BUCKET_COUNT - 1), "bucket out of range")
  `HSD_ASSERT_IMPL(a_store_only_new, key_we, vld_we && !found_r && state_r == ST_DECIDE, "key stored without a matching new result")
  `HSD_ASSERT_IMPL(a_one_flag, out_valid, !(out_is_new && out_bucket_full), "both result flags set")
  `HSD_ASSERT_NEXT(a_result_loaded, state_r == ST_DECIDE && can_emit, out_valid, "result word not presented")

endmodule

/* tb/sv/hsd_set_shadow_pkg.sv */
// Scoreboard for the hash set insert block: a shadow copy of the bucket table and
// the queue of verdicts it predicts. Depends on hsd_pkg for the key width and sizes.
`timescale 1ns / 1ps

package hsd_set_shadow_pkg;
  import hsd_pkg::*;

  localparam int BUCKETS = BUCKET_COUNT_DEF;
  localparam int SLOTS   = SLOTS_PER_BUCKET_DEF;

  typedef struct packed {
    logic is_new;
    logic bucket_full;
  } verdict_t;

  class hash_set_shadow;
    bit [SLOTS-1:0]   occupied [BUCKETS];
    logic [KEY_W-1:0] stored   [BUCKETS*SLOTS];
    verdict_t         pending_verdicts [$];
    int               mismatches;

    function new();
      foreach (occupied[i]) occupied[i] = '0;
      mismatches = 0;
    endfunction

    // Non-negative remainder of the signed key.
    function int bucket_of(logic signed [KEY_W-1:0] key);
      longint value;
      longint rem;
      value = key;
      rem = value % BUCKETS;
      if (rem < 0) rem += BUCKETS;
      return int'(rem);
    endfunction

    // Applies one accepted key to the shadow table and queues its verdict.
    function void record_key(logic signed [KEY_W-1:0] key);
      int       b;
      bit       found;
      bit       placed;
      verdict_t v;
      b = bucket_of(key);
      found = 1'b0;
      placed = 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        if (occupied[b][s] && stored[b*SLOTS+s] == key) found = 1'b1;
      end
      if (!found) begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!placed && !occupied[b][s]) begin
            stored[b*SLOTS+s] = key;
            occupied[b][s] = 1'b1;
            placed = 1'b1;
          end
        end
      end
      v.is_new = placed;
      v.bucket_full = !found && !placed;
      pending_verdicts.push_back(v);
    endfunction

    // Compares one accepted result word with the oldest queued verdict.
    function void check_result(logic is_new, logic bucket_full);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: is_new=%b bucket_full=%b", is_new, bucket_full);
        mismatches++;
        return;
      end
      v = pending_verdicts.pop_front();
      if (is_new !== v.is_new || bucket_full !== v.bucket_full) begin
        if (mismatches < 10)
          $display("result mismatch: expected is_new=%b bucket_full=%b, got %b %b",
                   v.is_new, v.bucket_full, is_new, bucket_full);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

endpackage

/* tb/sv/hash_set_dedup_insert_test.sv */
// Top-level testbench for hash_set_dedup_insert: clock, reset, key stimulus, result sink.
// Depends on hsd_pkg, hsd_set_shadow_pkg and the hash_set_dedup_insert RTL.
`timescale 1ns / 1ps

module hash_set_dedup_insert_test;
  import hsd_pkg::*;
  import hsd_set_shadow_pkg::*;

  // The block handles one key at a time and runs a clearing pass over every
  // bucket after reset. The limit leaves several times the slowest run.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 650;
  localparam int HOT          = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [KEY_W-1:0] in_key = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_is_new;
  logic out_bucket_full;

  hash_set_shadow set_shadow = new();

  // Idle percentages of both sides, changed by the stimulus between phases.
  int send_idle_pct = 36;
  int recv_idle_pct = 86;

  // The sender raises hold_req to make the receiver stall for a long stretch.
  bit hold_req = 1'b0;
  int hold_left = 0;

  int cycle_count = 0;
  int hot_buckets [HOT];
  logic signed [KEY_W-1:0] seen_keys [$];

  hash_set_dedup_insert dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_new      (out_is_new),
    .out_bucket_full (out_bucket_full)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // A run that never drains counts as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result sink. Handshake signals are read right after the edge, so they
  // still hold the values that the edge itself saw. The receiver either
  // serves a long hold-off, counted here, or idles at random.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        set_shadow.check_result(out_is_new, out_bucket_full);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Number of idle cycles before the next word; a run of idle draws gives
  // gaps of every length up to the cap, so they land on every stage of the block's work.
  function automatic int draw_gap(int pct);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < pct) gap++;
    return gap;
  endfunction

  // Most random keys land in a few hot buckets, chosen from a small pool of
  // values per bucket, so buckets fill up and duplicates and overflow occur.
  // Half of those keys are negative. Others repeat a recent key or are
  // drawn from the full 32-bit range.
  function automatic logic signed [KEY_W-1:0] next_random_key();
    int     pick;
    int     b;
    int     idx;
    longint m;
    longint v;
    pick = $urandom_range(99);
    if (pick < 55) begin
      b = hot_buckets[$urandom_range(HOT-1)];
      idx = $urandom_range(15);
      m = longint'(idx % 8) * 262144 + b;
      if (idx >= 8) v = longint'(b - BUCKETS) - longint'(BUCKETS) * m;
      else v = longint'(b) + longint'(BUCKETS) * m;
      return v[KEY_W-1:0];
    end else if (pick < 70 && seen_keys.size() > 0) begin
      return seen_keys[$urandom_range(seen_keys.size()-1)];
    end
    return $urandom();
  endfunction

  // Offers one key and returns once it is accepted. Valid stays high after
  // acceptance, so back-to-back words keep it up without a dip.
  task automatic offer_key(input logic signed [KEY_W-1:0] key);
    int gap;
    gap = draw_gap(send_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key <= key;
    do @(posedge clk); while (in_ready !== 1'b1);
    set_shadow.record_key(key);
    seen_keys.push_back(key);
    if (seen_keys.size() > 64) void'(seen_keys.pop_front());
  endtask

  // Drops valid and waits until every queued verdict has been matched.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (set_shadow.pending() != 0);
  endtask

  initial begin
    logic signed [KEY_W-1:0] corner_keys [17];
    corner_keys = '{
      32'sd0, 32'sd0,                         // first key, then its duplicate
      -32'sd1,                                // negative key wraps to the top bucket
      32'sh7FFFFFFF, 32'sh80000000,           // field extremes
      32'sd1021, 32'sd2042, 32'sd3063,        // fill bucket zero
      32'sd4084, -32'sd1021,                  // bucket zero is full now
      32'sd1021,                              // duplicate inside a full bucket
      -32'sd1, 32'sd1020, -32'sd1022,         // the top bucket from both signs
      -32'sd2043, -32'sd3064,                 // top bucket fills, then overflows
      32'sh80000000                           // extreme repeated
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_keys[i]) offer_key(corner_keys[i]);

    for (int phase = 0; phase < 3; phase++) begin
      // Sender idles lightly and receiver heavily, then the reverse, then
      // neither idles at all.
      case (phase)
        0: begin send_idle_pct = 36; recv_idle_pct = 86; end
        1: begin send_idle_pct = 86; recv_idle_pct = 36; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      foreach (hot_buckets[i]) hot_buckets[i] = $urandom_range(BUCKETS-1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // A long receiver stall while the sender keeps offering fills the
        // output register and holds the block in its last step, so in_ready must fall.
        if (i == 100) hold_req = 1'b1;
        // A full drain halfway through each phase.
        if (i == PHASE_ITEMS / 2) wait_for_drain();
        offer_key(next_random_key());
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (set_shadow.mismatches == 0 && set_shadow.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
